FILE: rtl/ypid_pkg.sv
// Shared types, constants and register map of the yaw PID servo controller.
package ypid_pkg;

  // Parameter defaults
  localparam int FRAC_BITS_DEF  = 8;
  localparam int MAX_GAP_MS_DEF = 500;

  // Fixed constants of the control law
  localparam int LIMIT_DEG  = 60;
  localparam int ALPHA_ONE  = 256;
  localparam int ALPHA_BITS = 8;
  localparam int MS_PER_S   = 1000;
  localparam int PULSE_MIN  = 600;
  localparam int PULSE_MAX  = 2400;

  // Field widths
  localparam int E_W      = 17;
  localparam int TIME_W   = 32;
  localparam int GAIN_W   = 16;
  localparam int ALPHA_W  = 9;
  localparam int CENTER_W = 12;
  localparam int OFS_W    = 10;
  localparam int PULSE_W  = 12;
  localparam int INTEG_W  = 24;
  localparam int DF_W     = 32;
  localparam int MS_W     = 10;

  // Shared multiplier operand widths
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 18;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Divider radix
  localparam int DIV_BITS_PER_CYCLE = 2;

  // Register map
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam logic [2:0] REG_PROP_GAIN    = 3'd0;
  localparam logic [2:0] REG_INTEG_GAIN   = 3'd1;
  localparam logic [2:0] REG_DERIV_GAIN   = 3'd2;
  localparam logic [2:0] REG_INTEG_LIMIT  = 3'd3;
  localparam logic [2:0] REG_DERIV_ALPHA  = 3'd4;
  localparam logic [2:0] REG_SERVO_CENTER = 3'd5;
  localparam logic [2:0] REG_MAX_OFFSET   = 3'd6;

  typedef struct packed {
    logic [GAIN_W-1:0]   prop_gain;
    logic [GAIN_W-1:0]   integ_gain;
    logic [GAIN_W-1:0]   deriv_gain;
    logic [GAIN_W-1:0]   integ_limit;
    logic [ALPHA_W-1:0]  deriv_alpha;
    logic [CENTER_W-1:0] servo_center;
    logic [OFS_W-1:0]    max_offset;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    prop_gain:    16'd768,
    integ_gain:   16'd26,
    deriv_gain:   16'd205,
    integ_limit:  16'd7680,
    deriv_alpha:  9'd179,
    servo_center: 12'd1500,
    max_offset:   10'd400
  };

  typedef enum logic [4:0] {
    S_IDLE,
    S_P,
    S_PADD,
    S_IDIV,
    S_IWAIT,
    S_I,
    S_IADD,
    S_DDIV,
    S_DWAIT,
    S_DF1,
    S_DF2,
    S_DF3,
    S_D,
    S_DADD,
    S_U,
    S_OMUL,
    S_ODIV,
    S_OWAIT,
    S_OUT
  } state_t;

endpackage

FILE: rtl/ypid_mul.sv
// Shared signed multiplier with a registered product.
module ypid_mul (
  input  logic                                   clk,
  input  logic signed [ypid_pkg::MUL_A_W-1:0]    a,
  input  logic signed [ypid_pkg::MUL_B_W-1:0]    b,
  output logic signed [ypid_pkg::MUL_P_W-1:0]    prod
);

  logic signed [ypid_pkg::MUL_P_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= ypid_pkg::MUL_P_W'(a) * ypid_pkg::MUL_P_W'(b);
  end

  assign prod = prod_r;

endmodule

FILE: rtl/ypid_div.sv
// Iterative signed-by-unsigned divider, truncating toward zero, two bits per cycle.
module ypid_div #(
  parameter int DVW = 28,
  parameter int DSW = 14
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic signed [DVW-1:0] dividend,
  input  logic        [DSW-1:0] divisor,
  output logic                  done,
  output logic signed [DVW-1:0] quotient
);

  localparam int STEPS = ypid_pkg::DIV_BITS_PER_CYCLE;
  localparam int ITER  = DVW / STEPS;
  localparam int CNT_W = $clog2(ITER + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             neg_r;
  logic [DVW-1:0]   quo_r;
  logic [DSW:0]     rem_r;
  logic [DSW-1:0]   den_r;
  logic [DVW-1:0]   quo_step;
  logic [DSW:0]     rem_step;
  logic [DVW-1:0]   mag;

  assign mag = dividend[DVW-1] ? DVW'(-dividend) : DVW'(dividend);

  // Restoring steps on the running remainder
  always_comb begin
    quo_step = quo_r;
    rem_step = rem_r;
    for (int k = 0; k < STEPS; k++) begin
      rem_step = {rem_step[DSW-1:0], quo_step[DVW-1]};
      quo_step = {quo_step[DVW-2:0], 1'b0};
      if (rem_step >= {1'b0, den_r}) begin
        rem_step    = rem_step - {1'b0, den_r};
        quo_step[0] = 1'b1;
      end
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(ITER);
    end else if (busy_r) begin
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= mag;
      rem_r <= '0;
      den_r <= divisor;
      neg_r <= dividend[DVW-1];
    end else if (busy_r) begin
      quo_r <= quo_step;
      rem_r <= rem_step;
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? -$signed(quo_r) : $signed(quo_r);

endmodule

FILE: rtl/ypid_core.sv
// Sequencer, state and datapath of the PID law around the shared multiplier and divider.
module ypid_core #(
  parameter int FRAC_BITS  = ypid_pkg::FRAC_BITS_DEF,
  parameter int MAX_GAP_MS = ypid_pkg::MAX_GAP_MS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  ypid_pkg::cfg_t                        cfg,
  input  logic                                  start,
  input  logic signed [ypid_pkg::E_W-1:0]       in_yaw_error,
  input  logic        [ypid_pkg::TIME_W-1:0]    in_now_ms,
  output logic                                  ready,
  output logic                                  res_valid,
  input  logic                                  res_ready,
  output logic        [ypid_pkg::PULSE_W-1:0]   res_pulse
);

  localparam int AW    = ypid_pkg::MUL_A_W;
  localparam int BW    = ypid_pkg::MUL_B_W;
  localparam int PW    = ypid_pkg::MUL_P_W;
  localparam int ACCW  = PW + 2;
  localparam int TW    = PW + 1;
  localparam int EW    = ypid_pkg::E_W;
  localparam int IW    = ypid_pkg::INTEG_W;
  localparam int DFW   = ypid_pkg::DF_W;
  localparam int GAP_W = $clog2(MAX_GAP_MS + 1);
  localparam int LIM_V = ypid_pkg::LIMIT_DEG << FRAC_BITS;
  localparam int LIM_W = $clog2(LIM_V + 1);
  // Dividend widths: error times gap, error step times 1000, drive times offset
  localparam int DV_A  = EW + GAP_W;
  localparam int DV_B  = EW + 1 + ypid_pkg::MS_W;
  localparam int DV_C  = LIM_W + 1 + ypid_pkg::OFS_W;
  localparam int DV_AB = (DV_A > DV_B) ? DV_A : DV_B;
  localparam int DV_RAW = (DV_AB > DV_C) ? DV_AB : DV_C;
  localparam int DVW   = ((DV_RAW + ypid_pkg::DIV_BITS_PER_CYCLE - 1) /
                          ypid_pkg::DIV_BITS_PER_CYCLE) * ypid_pkg::DIV_BITS_PER_CYCLE;
  localparam int DS_A  = (ypid_pkg::MS_W > GAP_W) ? ypid_pkg::MS_W : GAP_W;
  localparam int DSW   = (DS_A > LIM_W) ? DS_A : LIM_W;
  localparam int ISW   = ((DVW > IW) ? DVW : IW) + 1;
  localparam int PSW   = ypid_pkg::PULSE_W + 2;

  localparam logic signed [PW-1:0]   FRAC_ADJ = (PW'(1) <<< FRAC_BITS) - PW'(1);
  localparam logic signed [TW-1:0]   ALPHA_ADJ = TW'(ypid_pkg::ALPHA_ONE - 1);
  localparam logic signed [TW-1:0]   DF_MAX = TW'(32'sh7FFF_FFFF);
  localparam logic signed [TW-1:0]   DF_MIN = TW'($signed(32'h8000_0000));
  localparam logic signed [ACCW-1:0] U_MAX = ACCW'(LIM_V);
  localparam logic signed [ACCW-1:0] U_MIN = -ACCW'(LIM_V);
  localparam logic signed [PSW-1:0]  P_MIN = PSW'(ypid_pkg::PULSE_MIN);
  localparam logic signed [PSW-1:0]  P_MAX = PSW'(ypid_pkg::PULSE_MAX);

  ypid_pkg::state_t state_r, state_nxt;

  logic        [ypid_pkg::TIME_W-1:0] last_time_r, last_time_nxt;
  logic                               started_r, started_nxt;
  logic signed [IW-1:0]               integral_r, integral_nxt;
  logic signed [EW-1:0]               prev_error_r, prev_error_nxt;
  logic signed [DFW-1:0]              df_r, df_nxt;
  logic signed [EW-1:0]               e_r, e_nxt;
  logic        [GAP_W-1:0]            dt_r, dt_nxt;
  logic signed [ACCW-1:0]             acc_r, acc_nxt;
  logic signed [TW-1:0]               tmp_r, tmp_nxt;
  logic        [ypid_pkg::PULSE_W-1:0] res_r, res_nxt;

  logic signed [AW-1:0]  mul_a;
  logic signed [BW-1:0]  mul_b;
  logic signed [PW-1:0]  mul_q;
  logic                  div_start;
  logic signed [DVW-1:0] div_dividend;
  logic        [DSW-1:0] div_divisor;
  logic                  div_done;
  logic signed [DVW-1:0] div_quot;

  logic [ypid_pkg::TIME_W-1:0] gap;
  logic                        upd_i, upd_d;
  logic [ypid_pkg::ALPHA_W-1:0] alpha, alpha_inv;
  logic signed [ISW-1:0]       isum, ilim;
  logic signed [TW-1:0]        fadj, fsh;
  logic signed [PSW-1:0]       psum;

  // Divide by 2^FRAC_BITS, rounding toward zero
  function automatic logic signed [PW-1:0] frac_drop(input logic signed [PW-1:0] x);
    logic signed [PW-1:0] adj;
    adj = x + (x[PW-1] ? FRAC_ADJ : PW'(0));
    return adj >>> FRAC_BITS;
  endfunction

  ypid_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (mul_q)
  );

  ypid_div #(
    .DVW (DVW),
    .DSW (DSW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign gap       = in_now_ms - last_time_r;
  assign upd_i     = (dt_r != '0) && (cfg.integ_gain != '0);
  assign upd_d     = (dt_r != '0) && (cfg.deriv_gain != '0);
  assign alpha     = (cfg.deriv_alpha > ypid_pkg::ALPHA_W'(ypid_pkg::ALPHA_ONE)) ?
                     ypid_pkg::ALPHA_W'(ypid_pkg::ALPHA_ONE) : cfg.deriv_alpha;
  assign alpha_inv = ypid_pkg::ALPHA_W'(ypid_pkg::ALPHA_ONE) - alpha;
  assign isum      = ISW'(integral_r) + ISW'(div_quot);
  assign ilim      = ISW'($signed({1'b0, cfg.integ_limit}));
  assign fadj      = tmp_r + (tmp_r[TW-1] ? ALPHA_ADJ : TW'(0));
  assign fsh       = fadj >>> ypid_pkg::ALPHA_BITS;
  assign psum      = PSW'($signed({1'b0, cfg.servo_center})) + PSW'(div_quot);

  always_comb begin
    state_nxt      = state_r;
    last_time_nxt  = last_time_r;
    started_nxt    = started_r;
    integral_nxt   = integral_r;
    prev_error_nxt = prev_error_r;
    df_nxt         = df_r;
    e_nxt          = e_r;
    dt_nxt         = dt_r;
    acc_nxt        = acc_r;
    tmp_nxt        = tmp_r;
    res_nxt        = res_r;
    mul_a          = '0;
    mul_b          = '0;
    div_start      = 1'b0;
    div_dividend   = '0;
    div_divisor    = '0;
    ready          = 1'b0;
    res_valid      = 1'b0;

    case (state_r)
      ypid_pkg::S_IDLE: begin
        ready = 1'b1;
        if (start) begin
          e_nxt         = in_yaw_error;
          dt_nxt        = (started_r && (gap <= ypid_pkg::TIME_W'(MAX_GAP_MS))) ?
                          GAP_W'(gap) : '0;
          last_time_nxt = in_now_ms;
          started_nxt   = 1'b1;
          state_nxt     = ypid_pkg::S_P;
        end
      end
      ypid_pkg::S_P: begin
        mul_a     = AW'(e_r);
        mul_b     = BW'($signed({1'b0, cfg.prop_gain}));
        state_nxt = ypid_pkg::S_PADD;
      end
      ypid_pkg::S_PADD: begin
        acc_nxt = ACCW'(frac_drop(mul_q));
        if (upd_i) begin
          mul_a     = AW'(e_r);
          mul_b     = BW'($signed({1'b0, dt_r}));
          state_nxt = ypid_pkg::S_IDIV;
        end else begin
          state_nxt = ypid_pkg::S_I;
        end
      end
      ypid_pkg::S_IDIV: begin
        div_start    = 1'b1;
        div_dividend = DVW'(mul_q);
        div_divisor  = DSW'(ypid_pkg::MS_PER_S);
        state_nxt    = ypid_pkg::S_IWAIT;
      end
      ypid_pkg::S_IWAIT: begin
        if (div_done) begin
          if (isum > ilim) begin
            integral_nxt = IW'(ilim);
          end else if (isum < -ilim) begin
            integral_nxt = IW'(-ilim);
          end else begin
            integral_nxt = IW'(isum);
          end
          state_nxt = ypid_pkg::S_I;
        end
      end
      ypid_pkg::S_I: begin
        mul_a     = AW'(integral_r);
        mul_b     = BW'($signed({1'b0, cfg.integ_gain}));
        state_nxt = ypid_pkg::S_IADD;
      end
      ypid_pkg::S_IADD: begin
        acc_nxt = acc_r + ACCW'(frac_drop(mul_q));
        if (upd_d) begin
          mul_a     = AW'(e_r) - AW'(prev_error_r);
          mul_b     = BW'(ypid_pkg::MS_PER_S);
          state_nxt = ypid_pkg::S_DDIV;
        end else begin
          state_nxt = ypid_pkg::S_U;
        end
      end
      ypid_pkg::S_DDIV: begin
        div_start    = 1'b1;
        div_dividend = DVW'(mul_q);
        div_divisor  = DSW'(dt_r);
        state_nxt    = ypid_pkg::S_DWAIT;
      end
      ypid_pkg::S_DWAIT: begin
        if (div_done) begin
          mul_a     = AW'(div_quot);
          mul_b     = BW'($signed({1'b0, alpha_inv}));
          state_nxt = ypid_pkg::S_DF1;
        end
      end
      ypid_pkg::S_DF1: begin
        tmp_nxt   = TW'(mul_q);
        mul_a     = AW'(df_r);
        mul_b     = BW'($signed({1'b0, alpha}));
        state_nxt = ypid_pkg::S_DF2;
      end
      ypid_pkg::S_DF2: begin
        tmp_nxt   = tmp_r + TW'(mul_q);
        state_nxt = ypid_pkg::S_DF3;
      end
      ypid_pkg::S_DF3: begin
        if (fsh > DF_MAX) begin
          df_nxt = DFW'(DF_MAX);
        end else if (fsh < DF_MIN) begin
          df_nxt = DFW'(DF_MIN);
        end else begin
          df_nxt = DFW'(fsh);
        end
        state_nxt = ypid_pkg::S_D;
      end
      ypid_pkg::S_D: begin
        mul_a     = AW'(df_r);
        mul_b     = BW'($signed({1'b0, cfg.deriv_gain}));
        state_nxt = ypid_pkg::S_DADD;
      end
      ypid_pkg::S_DADD: begin
        acc_nxt   = acc_r + ACCW'(frac_drop(mul_q));
        state_nxt = ypid_pkg::S_U;
      end
      ypid_pkg::S_U: begin
        if (acc_r > U_MAX) begin
          acc_nxt = U_MAX;
        end else if (acc_r < U_MIN) begin
          acc_nxt = U_MIN;
        end
        prev_error_nxt = e_r;
        state_nxt      = ypid_pkg::S_OMUL;
      end
      ypid_pkg::S_OMUL: begin
        mul_a     = AW'(acc_r);
        mul_b     = BW'($signed({1'b0, cfg.max_offset}));
        state_nxt = ypid_pkg::S_ODIV;
      end
      ypid_pkg::S_ODIV: begin
        div_start    = 1'b1;
        div_dividend = DVW'(mul_q);
        div_divisor  = DSW'(LIM_V);
        state_nxt    = ypid_pkg::S_OWAIT;
      end
      ypid_pkg::S_OWAIT: begin
        if (div_done) begin
          if (psum > P_MAX) begin
            res_nxt = ypid_pkg::PULSE_W'(P_MAX);
          end else if (psum < P_MIN) begin
            res_nxt = ypid_pkg::PULSE_W'(P_MIN);
          end else begin
            res_nxt = ypid_pkg::PULSE_W'(psum);
          end
          state_nxt = ypid_pkg::S_OUT;
        end
      end
      ypid_pkg::S_OUT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ypid_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ypid_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ypid_pkg::S_IDLE;
      last_time_r  <= '0;
      started_r    <= 1'b0;
      integral_r   <= '0;
      prev_error_r <= '0;
      df_r         <= '0;
    end else begin
      state_r      <= state_nxt;
      last_time_r  <= last_time_nxt;
      started_r    <= started_nxt;
      integral_r   <= integral_nxt;
      prev_error_r <= prev_error_nxt;
      df_r         <= df_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e_r   <= e_nxt;
    dt_r  <= dt_nxt;
    acc_r <= acc_nxt;
    tmp_r <= tmp_nxt;
    res_r <= res_nxt;
  end

  assign res_pulse = res_r;

endmodule

FILE: rtl/yaw_pid_servo_controller_top.sv
// Top level: register port, input stream, output register and the PID core.
//
//   channel   direction  handshake               payload
//   in_*      slave      in_tvalid / in_tready   tdata: yaw_error[16:0], now_ms[48:17]
//   out_*     master     out_tvalid / out_tready tdata: pulse_us[11:0]
//   cfg_*     APB slave  psel, penable, pready   seven registers at byte address 4*i
//
// A transaction with integral and derivative updates makes three passes through the
// shared two-bit-per-cycle divider; one with only the P term acting makes a single
// pass, for the output scaling.
// in_tready is high only while the sequencer is idle. A finished result waits in
// the output register, so the next transaction is taken while out_tready is low.
// Reset is synchronous; it restores the register defaults and clears the state.
module yaw_pid_servo_controller_top #(
  parameter int FRAC_BITS  = ypid_pkg::FRAC_BITS_DEF,
  parameter int MAX_GAP_MS = ypid_pkg::MAX_GAP_MS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Input stream
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [55:0]                          in_tdata,    // yaw_error, now_ms
  // Result stream
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [15:0]                          out_tdata,   // pulse_us
  // Register port
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [ypid_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [ypid_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [ypid_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                 cfg_pready
);

  ypid_pkg::cfg_t cfg_r, cfg_nxt;

  logic                            cfg_wr;
  logic [2:0]                      reg_idx;
  logic                            start;
  logic                            core_ready;
  logic                            res_valid;
  logic                            res_ready;
  logic [ypid_pkg::PULSE_W-1:0]    res_pulse;
  logic                            out_valid_r, out_valid_nxt;
  logic [ypid_pkg::PULSE_W-1:0]    out_pulse_r;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign reg_idx    = cfg_paddr[4:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (reg_idx)
        ypid_pkg::REG_PROP_GAIN:    cfg_nxt.prop_gain    = cfg_pwdata[15:0];
        ypid_pkg::REG_INTEG_GAIN:   cfg_nxt.integ_gain   = cfg_pwdata[15:0];
        ypid_pkg::REG_DERIV_GAIN:   cfg_nxt.deriv_gain   = cfg_pwdata[15:0];
        ypid_pkg::REG_INTEG_LIMIT:  cfg_nxt.integ_limit  = cfg_pwdata[15:0];
        ypid_pkg::REG_DERIV_ALPHA:  cfg_nxt.deriv_alpha  = cfg_pwdata[8:0];
        ypid_pkg::REG_SERVO_CENTER: cfg_nxt.servo_center = cfg_pwdata[11:0];
        ypid_pkg::REG_MAX_OFFSET:   cfg_nxt.max_offset   = cfg_pwdata[9:0];
        default: begin
          // drop writes beyond the map
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      ypid_pkg::REG_PROP_GAIN:    cfg_prdata = 32'(cfg_r.prop_gain);
      ypid_pkg::REG_INTEG_GAIN:   cfg_prdata = 32'(cfg_r.integ_gain);
      ypid_pkg::REG_DERIV_GAIN:   cfg_prdata = 32'(cfg_r.deriv_gain);
      ypid_pkg::REG_INTEG_LIMIT:  cfg_prdata = 32'(cfg_r.integ_limit);
      ypid_pkg::REG_DERIV_ALPHA:  cfg_prdata = 32'(cfg_r.deriv_alpha);
      ypid_pkg::REG_SERVO_CENTER: cfg_prdata = 32'(cfg_r.servo_center);
      ypid_pkg::REG_MAX_OFFSET:   cfg_prdata = 32'(cfg_r.max_offset);
      default:                    cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= ypid_pkg::CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_tready = core_ready;
  assign start     = in_tvalid & core_ready;

  ypid_core #(
    .FRAC_BITS  (FRAC_BITS),
    .MAX_GAP_MS (MAX_GAP_MS)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .start        (start),
    .in_yaw_error ($signed(in_tdata[16:0])),
    .in_now_ms    (in_tdata[48:17]),
    .ready        (core_ready),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res_pulse    (res_pulse)
  );

  // Output register: take a new result once the held one has gone
  assign res_ready = ~out_valid_r | out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_pulse_r <= res_pulse;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_pulse_r};

endmodule

FILE: dv/tb.sv
// Self-checking bench for the yaw PID servo controller: random streams, register sweeps, scoreboard.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ypid_pkg::*;

  localparam int          E_MAX        = 46080;   // +-180 degrees in Q8.8
  localparam int          QUIET_LIMIT  = 2000;
  localparam int          SETTLE       = 100;
  localparam int          PHASE_ITEMS  = 70;
  localparam int          PHASES       = 9;
  localparam logic [2:0]  REG_UNMAPPED = 3'd7;
  localparam longint      ONE          = longint'(1) << FRAC_BITS_DEF;

  class pulse_scoreboard;
    cfg_t               regs;
    logic [TIME_W-1:0]  last_ms;
    bit                 primed;
    longint             integ_acc;
    longint             prev_err;
    longint             deriv_avg;
    logic [PULSE_W-1:0] expected_pulses[$];
    int                 errors;

    function new();
      regs      = CFG_RESET;
      last_ms   = '0;
      primed    = 1'b0;
      integ_acc = 0;
      prev_err  = 0;
      deriv_avg = 0;
      errors    = 0;
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        REG_PROP_GAIN:    regs.prop_gain    = data[GAIN_W-1:0];
        REG_INTEG_GAIN:   regs.integ_gain   = data[GAIN_W-1:0];
        REG_DERIV_GAIN:   regs.deriv_gain   = data[GAIN_W-1:0];
        REG_INTEG_LIMIT:  regs.integ_limit  = data[GAIN_W-1:0];
        REG_DERIV_ALPHA:  regs.deriv_alpha  = data[ALPHA_W-1:0];
        REG_SERVO_CENTER: regs.servo_center = data[CENTER_W-1:0];
        REG_MAX_OFFSET:   regs.max_offset   = data[OFS_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] reg_value(logic [2:0] idx);
      logic [31:0] v;
      v = '0;
      case (idx)
        REG_PROP_GAIN:    v = regs.prop_gain;
        REG_INTEG_GAIN:   v = regs.integ_gain;
        REG_DERIV_GAIN:   v = regs.deriv_gain;
        REG_INTEG_LIMIT:  v = regs.integ_limit;
        REG_DERIV_ALPHA:  v = regs.deriv_alpha;
        REG_SERVO_CENTER: v = regs.servo_center;
        REG_MAX_OFFSET:   v = regs.max_offset;
        default: ;
      endcase
      return v;
    endfunction

    // Advance the controller state by one sample and queue the pulse it must produce.
    function void take_error_sample(logic signed [E_W-1:0] yaw, logic [TIME_W-1:0] stamp);
      longint            e, span, p, i, d, lim, keep, rate, u, offset, pulse;
      logic [TIME_W-1:0] gap;
      e   = longint'(yaw);
      gap = primed ? stamp - last_ms : '0;
      if (gap > MAX_GAP_MS_DEF) gap = '0;
      primed  = 1'b1;
      last_ms = stamp;
      span    = longint'(gap);

      p = longint'(regs.prop_gain) * e / ONE;

      if (span > 0 && regs.integ_gain != 0)
        integ_acc = clip(integ_acc + e * span / MS_PER_S,
                         -longint'(regs.integ_limit), longint'(regs.integ_limit));
      i = longint'(regs.integ_gain) * integ_acc / ONE;

      d = 0;
      if (span > 0 && regs.deriv_gain != 0) begin
        // alpha above one holds the filter
        keep = (regs.deriv_alpha > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(regs.deriv_alpha);
        rate = (e - prev_err) * MS_PER_S / span;
        deriv_avg = clip((keep * deriv_avg + (ALPHA_ONE - keep) * rate) / ALPHA_ONE,
                         -(longint'(1) << 31), (longint'(1) << 31) - 1);
        d = longint'(regs.deriv_gain) * deriv_avg / ONE;
      end
      prev_err = e;

      lim    = LIMIT_DEG * ONE;
      u      = clip(p + i + d, -lim, lim);
      offset = u * longint'(regs.max_offset) / lim;
      pulse  = clip(longint'(regs.servo_center) + offset, PULSE_MIN, PULSE_MAX);
      expected_pulses.push_back(pulse[PULSE_W-1:0]);
    endfunction

    task check_pulse(logic [PULSE_W-1:0] got);
      logic [PULSE_W-1:0] want;
      if (expected_pulses.size() == 0) begin
        report($sformatf("pulse_us %0d with no transaction pending", got));
        return;
      end
      want = expected_pulses.pop_front();
      if (got !== want) report($sformatf("pulse_us %0d, expected %0d", got, want));
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [55:0]           in_tdata;    // yaw_error[16:0], now_ms[48:17], zero pad
  logic                  out_tvalid;
  logic                  out_tready;
  logic [15:0]           out_tdata;   // pulse_us[11:0], zero pad
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  pulse_scoreboard sb;
  bit              no_stall;
  logic [31:0]     clock_ms;
  int              yaw_now;
  int              quiet;

  yaw_pid_servo_controller_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random back-pressure
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready <= no_stall || ($urandom_range(99) >= 30);
    end
  end

  // Monitor both streams at the rising edge; the watchdog counts edges with no transaction.
  initial begin
    quiet = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_pulse(out_tdata[PULSE_W-1:0]);
      if (rst_n && in_tvalid && in_tready) sb.take_error_sample(in_tdata[16:0], in_tdata[48:17]);
      if (rst_n && ((out_tvalid && out_tready) || (in_tvalid && in_tready))) begin
        quiet = 0;
      end else begin
        quiet++;
        if (quiet >= QUIET_LIMIT) begin
          $display("Simulation FAILED");
          $finish;
        end
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_item(input int yaw, input logic [31:0] stamp);
    while (!no_stall && $urandom_range(99) < 30) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, stamp, yaw[E_W-1:0]};
    do @(posedge clk); while (in_tready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (sb.expected_pulses.size() != 0);
  endtask

  task automatic cfg_access(input logic wr, input logic [2:0] idx, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    if (wr)
      sb.set_reg(idx, data);
    else if (cfg_prdata !== sb.reg_value(idx))
      sb.report($sformatf("register %0d reads %0h, expected %0h", idx, cfg_prdata,
                          sb.reg_value(idx)));
    @(negedge clk);
  endtask

  // Write every register, optionally poke the unmapped slot, then read all back.
  task automatic apply_setting(input logic [31:0] kp, ki, kd, lim, alpha, center, span,
                               input bit poke);
    cfg_access(1'b1, REG_PROP_GAIN, kp);
    cfg_access(1'b1, REG_INTEG_GAIN, ki);
    cfg_access(1'b1, REG_DERIV_GAIN, kd);
    cfg_access(1'b1, REG_INTEG_LIMIT, lim);
    cfg_access(1'b1, REG_DERIV_ALPHA, alpha);
    cfg_access(1'b1, REG_SERVO_CENTER, center);
    cfg_access(1'b1, REG_MAX_OFFSET, span);
    if (poke) cfg_access(1'b1, REG_UNMAPPED, $urandom());
    for (int r = 0; r <= REG_MAX_OFFSET; r++) cfg_access(1'b0, r[2:0], '0);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Mostly plausible sample streams: short steps in time, drifting error, with gaps and jumps.
  task automatic run_random(input int count);
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 60)      clock_ms += $urandom_range(50, 1);
      else if (pick < 70) clock_ms += $urandom_range(500, 51);
      else if (pick < 78) clock_ms += 0;
      else if (pick < 86) clock_ms += $urandom_range(MAX_GAP_MS_DEF + 3, MAX_GAP_MS_DEF - 3);
      else if (pick < 94) clock_ms += $urandom_range(100000, MAX_GAP_MS_DEF + 1);
      else                clock_ms  = $urandom();

      pick = $urandom_range(99);
      if (pick < 55)      yaw_now += int'($urandom_range(3000)) - 1500;
      else if (pick < 80) yaw_now  = int'($urandom_range(2 * E_MAX)) - E_MAX;
      else if (pick < 90) yaw_now  = ($urandom_range(1) != 0) ? E_MAX : -E_MAX;
      else                yaw_now  = int'($urandom_range(2)) - 1;
      if (yaw_now > E_MAX)       yaw_now = E_MAX;
      else if (yaw_now < -E_MAX) yaw_now = -E_MAX;

      // hold off now and then until the block has drained
      if ($urandom_range(99) == 0) wait_for_results();
      send_item(yaw_now, clock_ms);
    end
  endtask

  initial begin
    sb          = new();
    no_stall    = 1'b0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: first sample, extreme errors, gap boundary, repeated stamp, clamp, wrap
    send_item(0, 32'd0);
    send_item(E_MAX, 32'd1);
    send_item(-E_MAX, 32'd2);
    send_item(-E_MAX, 32'd502);
    send_item(E_MAX, 32'd1003);
    send_item(E_MAX, 32'd1003);
    send_item(E_MAX, 32'd1503);
    send_item(E_MAX, 32'd2003);
    send_item(-E_MAX, 32'd2503);
    send_item(-E_MAX, 32'd3003);
    send_item(-E_MAX, 32'd3503);
    send_item(100, 32'd3504);
    send_item(-1, 32'hFFFF_FFF0);
    send_item(1, 32'hFFFF_FFFF);
    send_item(-256, 32'h0000_0005);
    send_item(12800, 32'h0000_0006);
    send_item(-12800, 32'h0000_0007);
    send_item(0, 32'h8000_0000);
    wait_for_results();

    clock_ms = $urandom();
    yaw_now  = 0;
    for (int ph = 1; ph <= PHASES; ph++) begin
      case (ph)
        1: apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, ALPHA_ONE, PULSE_MAX, 900, 1'b0);
        2: apply_setting(0, 0, 16'hFFFF, 0, 0, PULSE_MIN, 900, 1'b0);
        3: apply_setting($urandom_range(65535), $urandom_range(65535), 0, 16'hFFFF,
                         9'h1FF, 12'hFFF, 10'h3FF, 1'b1);
        4: apply_setting($urandom_range(2000), $urandom_range(200), $urandom_range(1000),
                         $urandom_range(65535), $urandom_range(511, 257), 0, 10'h3FF, 1'b0);
        5: apply_setting(200, 16'hFFFF, 0, 16'hFFFF, 179, 1500, 400, 1'b0);
        // lowered integral clamp: applies from the next integral update
        6: apply_setting(200, 300, 205, 50, 128, 1500, 400, 1'b0);
        default: apply_setting($urandom_range(4000), $urandom_range(600), $urandom_range(2000),
                               $urandom_range(65535), $urandom_range(ALPHA_ONE),
                               $urandom_range(PULSE_MAX, PULSE_MIN), $urandom_range(900), 1'b0);
      endcase
      no_stall = (ph == 4);
      run_random(PHASE_ITEMS);
      wait_for_results();
    end
    no_stall = 1'b0;

    repeat (SETTLE) @(posedge clk);
    if (sb.errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
